@@ sv/vap_pkg.sv @@
// Shared types, constants and helpers for the oldest-steal voice allocator.
`timescale 1ns / 1ps
`default_nettype none

package vap_pkg;

  // Pool geometry
  localparam int VOICES_PER_POOL = 8;
  localparam int POOL_COUNT      = 4;
  localparam int VIDX_W          = (VOICES_PER_POOL > 1) ? $clog2(VOICES_PER_POOL) : 1;
  localparam int AGE_W           = 64;
  localparam int NOTE_W          = 7;
  localparam int MASK_W          = 8;

  typedef logic [VIDX_W-1:0] vidx_t;
  typedef logic [AGE_W-1:0]  age_t;
  typedef logic [1:0]        pool_t;
  typedef logic [NOTE_W-1:0] note_t;
  typedef logic [MASK_W-1:0] vmask_t;
  // Held flag on top of the note number
  typedef logic [NOTE_W:0]   slot_note_t;

  typedef enum logic [1:0] {
    ACT_ON  = 2'd0,
    ACT_OFF = 2'd1,
    ACT_ALL = 2'd2,
    ACT_NOP = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_COMMIT
  } state_t;

  // Search record handed from cell to cell
  typedef struct packed {
    logic    vld;
    action_t action;
    pool_t   pool;
    note_t   note;
    vmask_t  mask;
    vidx_t   pos;
    logic    free_found;
    vidx_t   free_idx;
    logic    rel_found;
    vidx_t   rel_idx;
    age_t    rel_age;
    vidx_t   all_idx;
    age_t    all_age;
    logic    off_found;
    vidx_t   off_idx;
    vmask_t  rel_mask;
  } carry_t;

  // Slot update broadcast to every cell
  typedef struct packed {
    logic    en;
    action_t action;
    pool_t   pool;
    vidx_t   idx;
    note_t   note;
    age_t    age;
  } commit_t;

  // Voice index falls inside the 8-bit masks
  function automatic logic in_mask_range(vidx_t pos);
    logic [5:0] p;
    p = 6'(pos);
    in_mask_range = (p < 6'd8);
  endfunction

  // Voices past the mask width always count as sounding
  function automatic logic voice_sounding(vmask_t mask, vidx_t pos);
    logic [5:0] p;
    p = 6'(pos);
    voice_sounding = (p >= 6'd8) ? 1'b1 : mask[p[2:0]];
  endfunction

endpackage

`default_nettype wire

@@ sv/vap_cell.sv @@
// One voice cell: holds that voice's slot in every pool and does one search step.
`timescale 1ns / 1ps
`default_nettype none

module vap_cell (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire vap_pkg::vidx_t   cell_idx,
  input  wire vap_pkg::carry_t  carry_in,
  input  wire vap_pkg::commit_t commit,
  output vap_pkg::carry_t       carry_out
);
  import vap_pkg::*;

  slot_note_t note_r [POOL_COUNT];
  age_t       age_r  [POOL_COUNT];
  carry_t     carry_r;
  carry_t     carry_nxt;

  slot_note_t cur_note;
  age_t       cur_age;
  logic       cur_held;

  assign cur_note  = note_r[carry_in.pool];
  assign cur_age   = age_r[carry_in.pool];
  assign cur_held  = cur_note[NOTE_W];
  assign carry_out = carry_r;

  // Search step for the voice at this position
  always_comb begin
    carry_nxt     = carry_in;
    carry_nxt.pos = carry_in.pos + vidx_t'(1);
    // first silent voice
    if (!carry_in.free_found && !voice_sounding(carry_in.mask, carry_in.pos)) begin
      carry_nxt.free_found = 1'b1;
      carry_nxt.free_idx   = carry_in.pos;
    end
    // oldest released slot, strict compare against the running best
    if (!cur_held && (cur_age < carry_in.rel_age)) begin
      carry_nxt.rel_found = 1'b1;
      carry_nxt.rel_idx   = carry_in.pos;
      carry_nxt.rel_age   = cur_age;
    end
    // oldest slot overall; voice 0 seeds the search
    if ((carry_in.pos == '0) || (cur_age < carry_in.all_age)) begin
      carry_nxt.all_idx = carry_in.pos;
      carry_nxt.all_age = cur_age;
    end
    // first held slot carrying the note
    if (!carry_in.off_found && (cur_note == {1'b1, carry_in.note})) begin
      carry_nxt.off_found = 1'b1;
      carry_nxt.off_idx   = carry_in.pos;
    end
    // held voices for release-all
    if (cur_held && in_mask_range(carry_in.pos)) begin
      carry_nxt.rel_mask[carry_in.pos[2:0]] = 1'b1;
    end
  end

  // Hand the record to the next cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      carry_r <= '0;
    end else begin
      carry_r <= carry_nxt;
    end
  end

  // Slot storage, updated by the commit broadcast
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int p = 0; p < POOL_COUNT; p++) begin
        note_r[p] <= '0;
        age_r[p]  <= '0;
      end
    end else if (commit.en) begin
      case (commit.action)
        ACT_ON: begin
          if (commit.idx == cell_idx) begin
            note_r[commit.pool] <= {1'b1, commit.note};
            age_r[commit.pool]  <= commit.age;
          end
        end
        ACT_OFF: begin
          if (commit.idx == cell_idx) begin
            note_r[commit.pool] <= {1'b0, commit.note};
          end
        end
        ACT_ALL: begin
          note_r[commit.pool][NOTE_W] <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ sv/voice_allocator_oldest_steal.sv @@
// Top level: voice allocator with oldest-note stealing over a chain of voice cells.
//
//   channel  direction  handshake              payload
//   in_      input      in_valid / in_stall    action, pool, note, active_mask
//   out_     output     out_valid / out_stall  voice, hit, release_mask
//
// An item walks the cell chain one voice per cycle, passing from the seed register through
// one register per cell to the finish register, and leaves through the out register.
// One item is in flight at a time; a new beat is taken while a result waits.
// A stalled result holds the commit, and the slot update, until the out register frees.
// Synchronous active-low reset empties all slots and clears the age counter.
`timescale 1ns / 1ps
`default_nettype none

module voice_allocator_oldest_steal (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] in_action,
  input  wire logic [1:0] in_pool,
  input  wire logic [6:0] in_note,
  input  wire logic [7:0] in_active_mask,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [2:0]      out_voice,
  output logic            out_hit,
  output logic [7:0]      out_release_mask
);
  import vap_pkg::*;

  state_t  state_r;
  state_t  state_nxt;
  carry_t  carry0_r;
  carry_t  carry0_nxt;
  carry_t  fin_r;
  carry_t  chain [VOICES_PER_POOL+1];
  commit_t commit;
  age_t    age_counter_r;
  age_t    age_next;
  logic    in_take;
  logic    commit_go;
  logic    out_valid_r;
  logic [2:0] out_voice_r;
  logic       out_hit_r;
  vmask_t     out_release_mask_r;
  vidx_t      pick_idx;
  logic [2:0] res_voice;
  logic       res_hit;
  vmask_t     res_mask;

  assign in_take  = in_valid && !in_stall;
  assign age_next = age_counter_r + age_t'(1);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (in_take) state_nxt = S_SCAN;
      S_SCAN:   if (chain[VOICES_PER_POOL].vld) state_nxt = S_COMMIT;
      S_COMMIT: if (commit_go) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // FSM outputs
  always_comb begin
    in_stall  = (state_r != S_IDLE);
    commit_go = (state_r == S_COMMIT) && (!out_valid_r || !out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Seed record for the head of the chain
  always_comb begin
    carry0_nxt     = '0;
    carry0_nxt.vld = in_take;
    if (in_take) begin
      carry0_nxt.action  = action_t'(in_action);
      carry0_nxt.pool    = in_pool;
      carry0_nxt.note    = in_note;
      carry0_nxt.mask    = in_active_mask;
      carry0_nxt.rel_age = '1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      carry0_r <= '0;
    end else begin
      carry0_r <= carry0_nxt;
    end
  end

  assign chain[0] = carry0_r;

  // Row of voice cells
  for (genvar k = 0; k < VOICES_PER_POOL; k++) begin : g_cell
    vap_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cell_idx  (vidx_t'(k)),
      .carry_in  (chain[k]),
      .commit    (commit),
      .carry_out (chain[k+1])
    );
  end

  // Hold the finished search until the result can go out
  always_ff @(posedge clk) begin
    if (chain[VOICES_PER_POOL].vld && (state_r == S_SCAN)) begin
      fin_r <= chain[VOICES_PER_POOL];
    end
  end

  // Slot choice for a note-on: silent voice, oldest released, oldest overall
  always_comb begin
    if (fin_r.free_found) begin
      pick_idx = fin_r.free_idx;
    end else if (fin_r.rel_found) begin
      pick_idx = fin_r.rel_idx;
    end else begin
      pick_idx = fin_r.all_idx;
    end
  end

  // Commit broadcast and result fields
  always_comb begin
    commit        = '0;
    commit.action = fin_r.action;
    commit.pool   = fin_r.pool;
    commit.note   = fin_r.note;
    commit.age    = age_next;
    res_voice     = '0;
    res_hit       = 1'b0;
    res_mask      = '0;
    case (fin_r.action)
      ACT_ON: begin
        commit.en  = commit_go;
        commit.idx = pick_idx;
        res_voice  = 3'(pick_idx);
        res_hit    = 1'b1;
      end
      ACT_OFF: begin
        commit.en  = commit_go && fin_r.off_found;
        commit.idx = fin_r.off_idx;
        if (fin_r.off_found) begin
          res_voice = 3'(fin_r.off_idx);
          res_hit   = 1'b1;
          if (in_mask_range(fin_r.off_idx)) begin
            res_mask[fin_r.off_idx[2:0]] = 1'b1;
          end
        end
      end
      ACT_ALL: begin
        commit.en = commit_go;
        res_mask  = fin_r.rel_mask;
        res_hit   = |fin_r.rel_mask;
      end
      default: begin
      end
    endcase
  end

  // Shared age counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      age_counter_r <= '0;
    end else if (commit.en && (commit.action == ACT_ON)) begin
      age_counter_r <= age_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (commit_go) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit_go) begin
      out_voice_r        <= res_voice;
      out_hit_r          <= res_hit;
      out_release_mask_r <= res_mask;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_voice        = out_voice_r;
  assign out_hit          = out_hit_r;
  assign out_release_mask = out_release_mask_r;

`ifndef SYNTHESIS
  // Slot updates happen only from the commit state
  a_commit_state: assert property (@(posedge clk) disable iff (!rst_n)
    commit.en |-> (state_r == S_COMMIT))
    else $error("slot commit outside commit state");

  // The chain delivers a search result only while a scan is pending
  a_chain_scan: assert property (@(posedge clk) disable iff (!rst_n)
    chain[VOICES_PER_POOL].vld |-> (state_r == S_SCAN))
    else $error("chain result with no scan pending");

  // A note-on always yields a hit
  a_on_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (commit_go && (fin_r.action == ACT_ON)) |=> (out_valid_r && out_hit_r))
    else $error("note-on without hit");

  // Age counter steps by one on each note-on stamp
  a_age_step: assert property (@(posedge clk) disable iff (!rst_n)
    (commit.en && (commit.action == ACT_ON)) |=>
      (age_counter_r == $past(age_counter_r) + age_t'(1)))
    else $error("age counter did not advance");
`endif

endmodule

`default_nettype wire

@@ test/alloc_checker.sv @@
// Result checker for the voice allocator: tracks slot state, predicts each result beat, compares.
`timescale 1ns / 1ps

module alloc_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [1:0] in_action,
  input  logic [1:0] in_pool,
  input  logic [6:0] in_note,
  input  logic [7:0] in_active_mask,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [2:0] out_voice,
  input  logic       out_hit,
  input  logic [7:0] out_release_mask,
  output int         fail_count,
  output int         pending,
  output int         checked
);
  import vap_pkg::*;

  localparam int SLOTS = POOL_COUNT * VOICES_PER_POOL;

  typedef struct packed {
    vidx_t  voice;
    logic   hit;
    vmask_t rel;
  } alloc_result_t;

  // Shadow of the slot table: held flag over note number, plus age stamp
  slot_note_t    slot_tag   [SLOTS];
  age_t          slot_stamp [SLOTS];
  age_t          stamp_ctr;
  alloc_result_t expected_q [$];

  // Voices past the mask width always sound
  function automatic logic is_sounding(vmask_t mask, int i);
    if (i >= MASK_W) return 1'b1;
    return mask[i];
  endfunction

  // Free voice first, then oldest released slot, then oldest slot overall
  function automatic int choose_voice(int base, vmask_t mask);
    int   best;
    age_t best_age;
    logic found;
    for (int i = 0; i < VOICES_PER_POOL; i++)
      if (!is_sounding(mask, i)) return i;
    best     = 0;
    best_age = '1;
    found    = 1'b0;
    // strict compare: a released slot aged all ones is skipped here
    for (int i = 0; i < VOICES_PER_POOL; i++) begin
      if (!slot_tag[base+i][NOTE_W] && slot_stamp[base+i] < best_age) begin
        best_age = slot_stamp[base+i];
        best     = i;
        found    = 1'b1;
      end
    end
    if (found) return best;
    best     = 0;
    best_age = slot_stamp[base];
    for (int i = 1; i < VOICES_PER_POOL; i++) begin
      if (slot_stamp[base+i] < best_age) begin
        best_age = slot_stamp[base+i];
        best     = i;
      end
    end
    return best;
  endfunction

  // Apply one input beat to the shadow table and return its result
  function automatic alloc_result_t predict_beat(action_t a, pool_t p, note_t n, vmask_t m);
    alloc_result_t r;
    int            base;
    int            v;
    r    = '0;
    base = int'(p) * VOICES_PER_POOL;
    case (a)
      ACT_ON: begin
        v                  = choose_voice(base, m);
        stamp_ctr          = stamp_ctr + 1'b1;
        slot_tag[base+v]   = {1'b1, n};
        slot_stamp[base+v] = stamp_ctr;
        r.voice            = vidx_t'(v);
        r.hit              = 1'b1;
      end
      ACT_OFF: begin
        // first held slot with this note only
        for (int i = 0; i < VOICES_PER_POOL; i++) begin
          if (!r.hit && slot_tag[base+i] == {1'b1, n}) begin
            slot_tag[base+i] = {1'b0, n};
            r.voice          = vidx_t'(i);
            r.hit            = 1'b1;
            if (i < MASK_W) r.rel[i] = 1'b1;
          end
        end
      end
      ACT_ALL: begin
        for (int i = 0; i < VOICES_PER_POOL; i++) begin
          if (slot_tag[base+i][NOTE_W]) begin
            slot_tag[base+i][NOTE_W] = 1'b0;
            if (i < MASK_W) r.rel[i] = 1'b1;
          end
        end
        r.hit = |r.rel;
      end
      default: ;  // unused code: no state change, all-zero result
    endcase
    return r;
  endfunction

  // Compare result beats first, then queue the prediction for an accepted input beat
  always @(posedge clk) begin : watch
    alloc_result_t want;
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_tag[i]   = '0;
        slot_stamp[i] = '0;
      end
      stamp_ctr = '0;
      expected_q.delete();
      fail_count = 0;
      pending    = 0;
      checked    = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $error("result beat with no expectation waiting: voice %0d hit %0d mask %02h",
                 out_voice, out_hit, out_release_mask);
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          checked++;
          if (out_voice !== want.voice) begin
            $error("voice: expected %0d, got %0d", want.voice, out_voice);
            fail_count++;
          end
          if (out_hit !== want.hit) begin
            $error("hit: expected %0d, got %0d", want.hit, out_hit);
            fail_count++;
          end
          if (out_release_mask !== want.rel) begin
            $error("release_mask: expected %02h, got %02h", want.rel, out_release_mask);
            fail_count++;
          end
        end
      end
      // append the prediction at the tail
      if (in_valid && !in_stall)
        expected_q = {expected_q, predict_beat(action_t'(in_action), pool_t'(in_pool),
                                               note_t'(in_note), vmask_t'(in_active_mask))};
      pending = expected_q.size();
    end
  end

endmodule

@@ test/tb_top.sv @@
// Top of the voice allocator testbench: clock, reset, stimulus, stall pattern and verdict.
`timescale 1ns / 1ps

module tb_top;
  import vap_pkg::*;

  localparam int CYCLE_LIMIT    = 400000;
  localparam int ITEMS_PER_MIX  = 360;
  localparam int DRAIN_CYCLES   = 40;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] in_action = '0;
  logic [1:0] in_pool = '0;
  logic [6:0] in_note = '0;
  logic [7:0] in_active_mask = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [2:0] out_voice;
  logic       out_hit;
  logic [7:0] out_release_mask;

  int   fail_count;
  int   pending;
  int   checked;
  int   cycles = 0;
  logic in_fire = 1'b0;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  int   act_count [4] = '{0, 0, 0, 0};
  // recently started notes per pool, so note-offs mostly find something
  note_t recent [POOL_COUNT][8];

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  voice_allocator_oldest_steal u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_action        (in_action),
    .in_pool          (in_pool),
    .in_note          (in_note),
    .in_active_mask   (in_active_mask),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_voice        (out_voice),
    .out_hit          (out_hit),
    .out_release_mask (out_release_mask)
  );

  alloc_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_action        (in_action),
    .in_pool          (in_pool),
    .in_note          (in_note),
    .in_active_mask   (in_active_mask),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_voice        (out_voice),
    .out_hit          (out_hit),
    .out_release_mask (out_release_mask),
    .fail_count       (fail_count),
    .pending          (pending),
    .checked          (checked)
  );

  // Input handshake seen at the edge, read back at the next falling edge
  always @(posedge clk) in_fire <= rst_n && in_valid && !in_stall;

  // Random receiver stalls
  always @(negedge clk) out_stall <= ($urandom_range(99) < recv_idle_pct);

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still outstanding", cycles, pending);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Drive one beat from a falling edge and hold it until taken
  task automatic send_beat(input action_t a, input pool_t p, input note_t n, input vmask_t m);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_action      <= a;
    in_pool        <= p;
    in_note        <= n;
    in_active_mask <= m;
    do @(negedge clk); while (!in_fire);
    act_count[a]++;
  endtask

  // Mostly note-on/off traffic on held notes, with full masks to force stealing
  task automatic send_random();
    int      r;
    action_t a;
    pool_t   p;
    note_t   n;
    vmask_t  m;
    r = $urandom_range(99);
    p = pool_t'($urandom_range(3));
    if (r < 48)      a = ACT_ON;
    else if (r < 86) a = ACT_OFF;
    else if (r < 95) a = ACT_ALL;
    else             a = ACT_NOP;
    // narrow note range half the time so the same note lands in several slots
    if ($urandom_range(1) != 0) n = note_t'($urandom_range(67, 60));
    else                        n = note_t'($urandom_range(127));
    if (a == ACT_OFF && $urandom_range(3) != 0) n = recent[p][$urandom_range(7)];
    r = $urandom_range(99);
    if (r < 40)      m = 8'hFF;
    else if (r < 70) m = vmask_t'($urandom_range(255));
    else             m = vmask_t'(~(8'h01 << $urandom_range(7)));
    if (a == ACT_ON) recent[p][$urandom_range(7)] = n;
    send_beat(a, p, n, m);
  endtask

  initial begin
    for (int p = 0; p < POOL_COUNT; p++)
      for (int k = 0; k < 8; k++)
        recent[p][k] = 7'd60;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 18;
    recv_idle_pct = 68;

    // Directed: empty table, unused code, free-voice picks
    send_beat(ACT_OFF, 2'd0, 7'd127, 8'h00);   // note-off with nothing held
    send_beat(ACT_ALL, 2'd0, 7'd0,   8'hFF);   // release-all with nothing held
    send_beat(ACT_NOP, 2'd3, 7'd127, 8'hFF);   // unused action code
    send_beat(ACT_ON,  2'd0, 7'd0,   8'h00);
    send_beat(ACT_ON,  2'd0, 7'd127, 8'h01);
    send_beat(ACT_ON,  2'd3, 7'd64,  8'h7F);   // only the top voice free
    send_beat(ACT_OFF, 2'd0, 7'd127, 8'hFF);   // found
    send_beat(ACT_OFF, 2'd0, 7'd127, 8'hFF);   // already released: miss
    send_beat(ACT_ON,  2'd0, 7'd5,   8'hFF);   // steal oldest released slot
    // fill pool 1 with all voices sounding, then steal the oldest held slot
    for (int k = 0; k < 9; k++)
      send_beat(ACT_ON, 2'd1, note_t'(40 + k), 8'hFF);
    send_beat(ACT_OFF, 2'd1, 7'd44,  8'hFF);
    send_beat(ACT_ON,  2'd1, 7'd100, 8'hFF);   // released slot wins over older held ones
    send_beat(ACT_ALL, 2'd1, 7'd0,   8'h00);
    // duplicate note: both note-ons take the first silent voice, then the note-off releases it
    send_beat(ACT_ON,  2'd2, 7'd33,  8'hAA);
    send_beat(ACT_ON,  2'd2, 7'd33,  8'hAA);
    send_beat(ACT_OFF, 2'd2, 7'd33,  8'hFF);

    // Random traffic under three idling mixes
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin send_idle_pct = 18; recv_idle_pct = 68; end
        1: begin send_idle_pct = 68; recv_idle_pct = 18; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      repeat (ITEMS_PER_MIX) send_random();
    end
    in_valid <= 1'b0;

    // Drain
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Drove %0d beats: %0d note-on, %0d note-off, %0d release-all, %0d unused code",
             act_count[0] + act_count[1] + act_count[2] + act_count[3],
             act_count[ACT_ON], act_count[ACT_OFF], act_count[ACT_ALL], act_count[ACT_NOP]);
    $display("Compared %0d results across sender-heavy, receiver-heavy and no-idle stall mixes",
             checked);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
